>>> rtl/hue_luma_selective_color_gain_core_defines.svh
// Assertion macros used by the core RTL file.
// Each check is clocked on clock and switched off while reset is high.
`ifndef HUE_LUMA_SELECTIVE_COLOR_GAIN_CORE_DEFINES_SVH
`define HUE_LUMA_SELECTIVE_COLOR_GAIN_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HLSCG_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("hlscg check failed");
`define HLSCG_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hlscg check failed");
`else
`define HLSCG_ASSERT(name, prop)
`define HLSCG_ASSERT_NEXT(name, ante, cons)
`endif

`endif

>>> rtl/hlscg_pkg.sv
package hlscg_pkg;

   // Field and port widths
   localparam int PIX_W      = 8;
   localparam int ADJ_W      = 8;
   localparam int SEL_W      = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // Gain fixed point
   localparam int GAIN_FRAC_BITS = 16;
   localparam int GAIN_W         = GAIN_FRAC_BITS + 4;

   // Factor products: factors fit 10-bit signed, |N| stays below 2^25
   localparam int FAC_W = 10;
   localparam int NUM_W = 3 * FAC_W;
   localparam int NU_W  = 25;

   // gain = floor((N * 2^F + 10^6) / (2 * 10^6))
   //      = floor(floor((N * 2^(F-6) + 15625) / 2) / 15625)
   localparam int ROUND_SHIFT = GAIN_FRAC_BITS - 6;
   localparam int DIV_CONST   = 1000000 / 64;
   localparam int DIV_W       = 14;
   localparam int NUMER_W     = NU_W + ROUND_SHIFT + 1;
   localparam int HALF_W      = NUMER_W - 1;
   localparam int DIV_K       = HALF_W;
   localparam int RECIP_W     = DIV_K - 13;
   localparam logic [63:0] RECIP_FULL = (64'd1 << DIV_K) / 64'(DIV_CONST);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
   localparam int LO_W  = (HALF_W + 1) / 2;
   localparam int HI_W  = HALF_W - LO_W;
   localparam int SUM_W = HALF_W + RECIP_W + 1;
   localparam int BACK_W = GAIN_W + DIV_W;

   // Channel scaling
   localparam int PROD_W = PIX_W + GAIN_W;
   localparam int SAT_W  = PROD_W - GAIN_FRAC_BITS;

   // Luma
   localparam int LUMA_W = 18;
   localparam logic [LUMA_W-1:0] LUMA_KR     = LUMA_W'(299);
   localparam logic [LUMA_W-1:0] LUMA_KG     = LUMA_W'(587);
   localparam logic [LUMA_W-1:0] LUMA_KB     = LUMA_W'(114);
   localparam logic [LUMA_W-1:0] LUMA_BRIGHT = LUMA_W'(168300);
   localparam logic [LUMA_W-1:0] LUMA_DARK   = LUMA_W'(84150);

   // Factor bases
   localparam logic signed [FAC_W-1:0] FAC_BASE       = FAC_W'(100);
   localparam logic signed [FAC_W-1:0] FAC_BLACK_BASE = FAC_W'(200);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_SELECT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CYAN_ADJUST    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGENTA_ADJUST = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_YELLOW_ADJUST  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLACK_ADJUST   = 3'd4;

   // Class select codes; hue sectors share the codes
   localparam logic [SEL_W-1:0] SEL_ALL         = 4'd0;
   localparam logic [SEL_W-1:0] SEL_HUE_RED     = 4'd1;
   localparam logic [SEL_W-1:0] SEL_HUE_YELLOW  = 4'd2;
   localparam logic [SEL_W-1:0] SEL_HUE_GREEN   = 4'd3;
   localparam logic [SEL_W-1:0] SEL_HUE_CYAN    = 4'd4;
   localparam logic [SEL_W-1:0] SEL_HUE_BLUE    = 4'd5;
   localparam logic [SEL_W-1:0] SEL_LUMA_BRIGHT = 4'd6;
   localparam logic [SEL_W-1:0] SEL_LUMA_MID    = 4'd7;
   localparam logic [SEL_W-1:0] SEL_LUMA_DARK   = 4'd8;

   // Pixel pipeline
   localparam int STAGES    = 9;
   localparam int MUL_STAGE = 7;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } pixel_type;

endpackage

>>> rtl/hlscg_gain.sv
// Seven-stage gain pipeline: factor product, rounding, reciprocal divide, correct.
module hlscg_gain (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic signed [hlscg_pkg::FAC_W-1:0]     fac_a,
   input  logic signed [hlscg_pkg::FAC_W-1:0]     fac_b,
   input  logic signed [hlscg_pkg::FAC_W-1:0]     fac_k,
   output logic        [hlscg_pkg::GAIN_W-1:0]    gain
);

   logic signed [2*hlscg_pkg::FAC_W-1:0] prod_ab_ff;
   logic signed [hlscg_pkg::FAC_W-1:0]   fac_k_ff;
   logic signed [hlscg_pkg::NUM_W-1:0]   num_ff;
   logic [hlscg_pkg::NUMER_W-1:0]        numer;
   logic [hlscg_pkg::HALF_W-1:0]         half_in, half_ff, half_d1_ff, half_d2_ff, half_d3_ff;
   logic [hlscg_pkg::LO_W+hlscg_pkg::RECIP_W-1:0] part_lo_ff;
   logic [hlscg_pkg::HI_W+hlscg_pkg::RECIP_W-1:0] part_hi_ff;
   logic [hlscg_pkg::SUM_W-1:0]          est_sum;
   logic [hlscg_pkg::GAIN_W-1:0]         est_ff, est_d_ff, gain_in, gain_ff;
   logic [hlscg_pkg::BACK_W-1:0]         back_ff;
   logic [hlscg_pkg::HALF_W-1:0]         rem;

   // Round-half-up numerator, halved; a non-positive product gives zero
   always_comb begin
      numer   = (hlscg_pkg::NUMER_W'(num_ff[hlscg_pkg::NU_W-1:0]) << hlscg_pkg::ROUND_SHIFT)
              + hlscg_pkg::NUMER_W'(hlscg_pkg::DIV_CONST);
      half_in = (num_ff > 0) ? numer[hlscg_pkg::NUMER_W-1:1] : '0;
   end

   // Estimate is exact or one low
   assign est_sum = (hlscg_pkg::SUM_W'(part_hi_ff) << hlscg_pkg::LO_W)
                  + hlscg_pkg::SUM_W'(part_lo_ff);

   always_comb begin
      rem     = half_d3_ff - hlscg_pkg::HALF_W'(back_ff);
      gain_in = (rem >= hlscg_pkg::HALF_W'(hlscg_pkg::DIV_CONST)) ? est_d_ff + 1'b1 : est_d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ab_ff <= '0;
         fac_k_ff   <= '0;
         num_ff     <= '0;
         half_ff    <= '0;
         half_d1_ff <= '0;
         half_d2_ff <= '0;
         half_d3_ff <= '0;
         part_lo_ff <= '0;
         part_hi_ff <= '0;
         est_ff     <= '0;
         est_d_ff   <= '0;
         back_ff    <= '0;
         gain_ff    <= '0;
      end else begin
         prod_ab_ff <= fac_a * fac_b;
         fac_k_ff   <= fac_k;
         num_ff     <= hlscg_pkg::NUM_W'(prod_ab_ff) * hlscg_pkg::NUM_W'(fac_k_ff);
         half_ff    <= half_in;
         part_lo_ff <= (hlscg_pkg::LO_W + hlscg_pkg::RECIP_W)'(half_ff[hlscg_pkg::LO_W-1:0])
                     * (hlscg_pkg::LO_W + hlscg_pkg::RECIP_W)'(hlscg_pkg::RECIP);
         part_hi_ff <= (hlscg_pkg::HI_W + hlscg_pkg::RECIP_W)'(
                          half_ff[hlscg_pkg::HALF_W-1:hlscg_pkg::LO_W])
                     * (hlscg_pkg::HI_W + hlscg_pkg::RECIP_W)'(hlscg_pkg::RECIP);
         half_d1_ff <= half_ff;
         est_ff     <= est_sum[hlscg_pkg::DIV_K +: hlscg_pkg::GAIN_W];
         half_d2_ff <= half_d1_ff;
         back_ff    <= hlscg_pkg::BACK_W'(est_ff) * hlscg_pkg::BACK_W'(hlscg_pkg::DIV_CONST);
         est_d_ff   <= est_ff;
         half_d3_ff <= half_d2_ff;
         gain_ff    <= gain_in;
      end
   end

   assign gain = gain_ff;

endmodule

>>> rtl/hue_luma_selective_color_gain_core.sv
// Hue/luma selective color gain.
// Request channel: drive start high with req_red_in, req_green_in and
// req_blue_in; the request is taken at a rising edge where start is high
// and busy is low. busy is high only during reset, so one pixel can be
// taken on every clock.
// Response channel: rsp_valid marks one cycle that carries rsp_red_out,
// rsp_green_out, rsp_blue_out and rsp_matched. Results come in request
// order, one per clock at full rate. The receiver cannot stall; there is
// no hold.
// Configuration: csr_write_enable, csr_index and csr_write_data write one
// register per cycle, no wait. Write only while no request is in flight.
// Each gain comes from a seven-stage arithmetic pipeline fed by the
// registers; that depth sets where the pixel path applies the gains.
// Reset clears the registers to zero, empties the pipeline and drops any
// request in flight.
`include "hue_luma_selective_color_gain_core_defines.svh"

module hue_luma_selective_color_gain_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [hlscg_pkg::PIX_W-1:0]          req_red_in,
   input  logic [hlscg_pkg::PIX_W-1:0]          req_green_in,
   input  logic [hlscg_pkg::PIX_W-1:0]          req_blue_in,
   output logic                                 rsp_valid,
   output logic [hlscg_pkg::PIX_W-1:0]          rsp_red_out,
   output logic [hlscg_pkg::PIX_W-1:0]          rsp_green_out,
   output logic [hlscg_pkg::PIX_W-1:0]          rsp_blue_out,
   output logic                                 rsp_matched,
   input  logic                                 csr_write_enable,
   input  logic [hlscg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hlscg_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   // Configuration registers
   logic [hlscg_pkg::SEL_W-1:0]        sel_ff;
   logic signed [hlscg_pkg::ADJ_W-1:0] cyan_ff, magenta_ff, yellow_ff, black_ff;

   // Gain factors and gains
   logic signed [hlscg_pkg::FAC_W-1:0] fac_cyan, fac_magenta, fac_yellow, fac_black;
   logic [hlscg_pkg::GAIN_W-1:0]       gain_red, gain_green, gain_blue;

   // Pixel pipeline
   logic                               accept;
   logic [hlscg_pkg::STAGES:1]         valid_ff;
   hlscg_pkg::pixel_type               pix_in;
   hlscg_pkg::pixel_type               pix_ff [1:hlscg_pkg::MUL_STAGE+1];
   logic [hlscg_pkg::SEL_W-1:0]        sector_in, sector_ff;
   logic [hlscg_pkg::LUMA_W-1:0]       luma_in, luma_ff;
   logic                               match_in;
   logic [hlscg_pkg::MUL_STAGE+1:3]    match_ff;
   logic [hlscg_pkg::PROD_W-1:0]       prod_red_ff, prod_green_ff, prod_blue_ff;
   logic [hlscg_pkg::PIX_W-1:0]        red_out_in, green_out_in, blue_out_in;
   logic [hlscg_pkg::PIX_W-1:0]        red_out_ff, green_out_ff, blue_out_ff;
   logic                               matched_in, matched_ff;

   // Drop the fraction and saturate the integer part above 255
   function automatic logic [hlscg_pkg::PIX_W-1:0] scale_sat(
      input logic [hlscg_pkg::PROD_W-1:0] prod
   );
      logic [hlscg_pkg::SAT_W-1:0] whole;
      whole = prod[hlscg_pkg::GAIN_FRAC_BITS +: hlscg_pkg::SAT_W];
      if (whole > hlscg_pkg::SAT_W'({hlscg_pkg::PIX_W{1'b1}})) begin
         return {hlscg_pkg::PIX_W{1'b1}};
      end
      return whole[hlscg_pkg::PIX_W-1:0];
   endfunction

   assign busy   = reset;
   assign accept = start & ~busy;

   // ---------------------------------------------------------------
   // Configuration port; indexes beyond the list are dropped
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff     <= hlscg_pkg::SEL_ALL;
         cyan_ff    <= '0;
         magenta_ff <= '0;
         yellow_ff  <= '0;
         black_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            hlscg_pkg::CSR_COLOR_SELECT:   sel_ff     <= csr_write_data[hlscg_pkg::SEL_W-1:0];
            hlscg_pkg::CSR_CYAN_ADJUST:    cyan_ff    <= csr_write_data;
            hlscg_pkg::CSR_MAGENTA_ADJUST: magenta_ff <= csr_write_data;
            hlscg_pkg::CSR_YELLOW_ADJUST:  yellow_ff  <= csr_write_data;
            hlscg_pkg::CSR_BLACK_ADJUST:   black_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Per-color factors in percent; black is in half percent
   assign fac_cyan    = hlscg_pkg::FAC_BASE - hlscg_pkg::FAC_W'(cyan_ff);
   assign fac_magenta = hlscg_pkg::FAC_BASE - hlscg_pkg::FAC_W'(magenta_ff);
   assign fac_yellow  = hlscg_pkg::FAC_BASE + hlscg_pkg::FAC_W'(yellow_ff);
   assign fac_black   = hlscg_pkg::FAC_BLACK_BASE + hlscg_pkg::FAC_W'(black_ff);

   // The gains follow the registers through the gain pipeline. A request taken
   // right after a write reaches the multiply stage no earlier than the new gains.
   hlscg_gain u_gain_red (
      .clock (clock),
      .reset (reset),
      .fac_a (fac_cyan),
      .fac_b (fac_magenta),
      .fac_k (fac_black),
      .gain  (gain_red)
   );

   hlscg_gain u_gain_green (
      .clock (clock),
      .reset (reset),
      .fac_a (fac_cyan),
      .fac_b (fac_yellow),
      .fac_k (fac_black),
      .gain  (gain_green)
   );

   hlscg_gain u_gain_blue (
      .clock (clock),
      .reset (reset),
      .fac_a (fac_magenta),
      .fac_b (fac_yellow),
      .fac_k (fac_black),
      .gain  (gain_blue)
   );

   // ---------------------------------------------------------------
   // Stage 1: capture the request
   // ---------------------------------------------------------------
   assign pix_in = '{red: req_red_in, green: req_green_in, blue: req_blue_in};

   // ---------------------------------------------------------------
   // Stage 2: hue sector by comparisons, luma sum
   // ---------------------------------------------------------------
   always_comb begin
      logic [hlscg_pkg::PIX_W-1:0] r, g, b;
      r = pix_ff[1].red;
      g = pix_ff[1].green;
      b = pix_ff[1].blue;
      if (r == g && g == b) begin
         // gray counts as hue zero
         sector_in = hlscg_pkg::SEL_HUE_RED;
      end else if (r >= g && r >= b) begin
         sector_in = (g == r) ? hlscg_pkg::SEL_HUE_YELLOW : hlscg_pkg::SEL_HUE_RED;
      end else if (g >= b) begin
         if (b < r) begin
            sector_in = hlscg_pkg::SEL_HUE_YELLOW;
         end else if (b < g) begin
            sector_in = hlscg_pkg::SEL_HUE_GREEN;
         end else begin
            sector_in = hlscg_pkg::SEL_HUE_CYAN;
         end
      end else begin
         sector_in = (r < g) ? hlscg_pkg::SEL_HUE_CYAN : hlscg_pkg::SEL_HUE_BLUE;
      end
      luma_in = hlscg_pkg::LUMA_W'(r) * hlscg_pkg::LUMA_KR
              + hlscg_pkg::LUMA_W'(g) * hlscg_pkg::LUMA_KG
              + hlscg_pkg::LUMA_W'(b) * hlscg_pkg::LUMA_KB;
   end

   // ---------------------------------------------------------------
   // Stage 3: class match against the selector
   // ---------------------------------------------------------------
   always_comb begin
      case (sel_ff)
         hlscg_pkg::SEL_ALL:         match_in = 1'b1;
         hlscg_pkg::SEL_LUMA_BRIGHT: match_in = luma_ff > hlscg_pkg::LUMA_BRIGHT;
         hlscg_pkg::SEL_LUMA_MID:    match_in = (luma_ff > hlscg_pkg::LUMA_DARK) &&
                                                (luma_ff <= hlscg_pkg::LUMA_BRIGHT);
         hlscg_pkg::SEL_LUMA_DARK:   match_in = luma_ff <= hlscg_pkg::LUMA_DARK;
         default: begin
            // hue sectors match by code; unused codes never match
            match_in = (sel_ff inside {[hlscg_pkg::SEL_HUE_RED:hlscg_pkg::SEL_HUE_BLUE]}) &&
                       (sector_ff == sel_ff);
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Stage 9: shift out the fraction, saturate, pick adjusted or input
   // ---------------------------------------------------------------
   always_comb begin
      matched_in = valid_ff[hlscg_pkg::STAGES-1] & match_ff[hlscg_pkg::MUL_STAGE+1];
      if (match_ff[hlscg_pkg::MUL_STAGE+1]) begin
         red_out_in   = scale_sat(prod_red_ff);
         green_out_in = scale_sat(prod_green_ff);
         blue_out_in  = scale_sat(prod_blue_ff);
      end else begin
         red_out_in   = pix_ff[hlscg_pkg::MUL_STAGE+1].red;
         green_out_in = pix_ff[hlscg_pkg::MUL_STAGE+1].green;
         blue_out_in  = pix_ff[hlscg_pkg::MUL_STAGE+1].blue;
      end
   end

   // Valid bits advance every cycle; the receiver never holds them
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         matched_ff <= 1'b0;
      end else begin
         valid_ff   <= {valid_ff[hlscg_pkg::STAGES-1:1], accept};
         matched_ff <= matched_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff[1] <= pix_in;
      for (int i = 2; i <= hlscg_pkg::MUL_STAGE + 1; i++) begin
         pix_ff[i] <= pix_ff[i-1];
      end
      sector_ff <= sector_in;
      luma_ff   <= luma_in;
      match_ff  <= {match_ff[hlscg_pkg::MUL_STAGE:3], match_in};
      // Stage 8: one multiply per channel
      prod_red_ff   <= hlscg_pkg::PROD_W'(pix_ff[hlscg_pkg::MUL_STAGE].red)
                     * hlscg_pkg::PROD_W'(gain_red);
      prod_green_ff <= hlscg_pkg::PROD_W'(pix_ff[hlscg_pkg::MUL_STAGE].green)
                     * hlscg_pkg::PROD_W'(gain_green);
      prod_blue_ff  <= hlscg_pkg::PROD_W'(pix_ff[hlscg_pkg::MUL_STAGE].blue)
                     * hlscg_pkg::PROD_W'(gain_blue);
      red_out_ff    <= red_out_in;
      green_out_ff  <= green_out_in;
      blue_out_ff   <= blue_out_in;
   end

   assign rsp_valid     = valid_ff[hlscg_pkg::STAGES];
   assign rsp_red_out   = red_out_ff;
   assign rsp_green_out = green_out_ff;
   assign rsp_blue_out  = blue_out_ff;
   assign rsp_matched   = matched_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   // Every response traces back to a request a fixed latency earlier
   `HLSCG_ASSERT(a_rsp_latency, rsp_valid |-> $past(start && !busy, hlscg_pkg::STAGES))
   // matched is never raised outside a response cycle
   `HLSCG_ASSERT(a_matched_in_rsp, rsp_matched |-> rsp_valid)
   // A zero red gain blacks out the red channel of a matched pixel
   `HLSCG_ASSERT(a_zero_gain_black,
      (rsp_valid && rsp_matched && ($past(gain_red, 2) == '0)) |-> (rsp_red_out == '0))
   // Selector codes past the luma bands match nothing
   `HLSCG_ASSERT_NEXT(a_unused_sel_no_match,
      valid_ff[2] && (sel_ff > hlscg_pkg::SEL_LUMA_DARK), !match_ff[3])

endmodule

>>> bench/tb_hue_luma_selective_color_gain_core.sv
module tb_hue_luma_selective_color_gain_core;

   localparam int HALF_PERIOD     = 2;
   localparam int RESET_CYCLES    = 10;
   localparam int PHASES          = 20;
   localparam int QUIET_PHASES    = 4;
   localparam int ITEMS_PER_PHASE = 22;
   localparam int SEL_SPAN        = 1 << hlscg_pkg::SEL_W;
   localparam int DRAIN_CYCLES    = 2 * hlscg_pkg::STAGES;
   localparam int RUN_LIMIT       = 400000;
   localparam int CORNER_COUNT    = 18;
   localparam int MAX_BURST       = 14;
   localparam logic [hlscg_pkg::PIX_W-1:0] PIX_MAX = {hlscg_pkg::PIX_W{1'b1}};

   // One result as it leaves the block: adjusted pixel plus class flag.
   typedef struct {
      logic [hlscg_pkg::PIX_W-1:0] red;
      logic [hlscg_pkg::PIX_W-1:0] green;
      logic [hlscg_pkg::PIX_W-1:0] blue;
      logic                        matched;
   } graded_pixel_type;

   // Holds a private copy of the registers, grades each accepted request
   // and compares the block's results against the oldest grade in line.
   class pixel_gain_scoreboard_type;
      logic [hlscg_pkg::SEL_W-1:0]        class_sel;
      logic signed [hlscg_pkg::ADJ_W-1:0] cyan;
      logic signed [hlscg_pkg::ADJ_W-1:0] magenta;
      logic signed [hlscg_pkg::ADJ_W-1:0] yellow;
      logic signed [hlscg_pkg::ADJ_W-1:0] black;
      graded_pixel_type                   graded_pixels[$];
      int                                 errors;

      function new();
         class_sel = hlscg_pkg::SEL_ALL;
         cyan = '0;
         magenta = '0;
         yellow = '0;
         black = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [hlscg_pkg::CSR_IDX_W-1:0] idx,
                              logic [hlscg_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            hlscg_pkg::CSR_COLOR_SELECT:   class_sel = data[hlscg_pkg::SEL_W-1:0];
            hlscg_pkg::CSR_CYAN_ADJUST:    cyan = data;
            hlscg_pkg::CSR_MAGENTA_ADJUST: magenta = data;
            hlscg_pkg::CSR_YELLOW_ADJUST:  yellow = data;
            hlscg_pkg::CSR_BLACK_ADJUST:   black = data;
            default: ;
         endcase
      endfunction

      // Sector by cross comparison of the channels; gray counts as red.
      function logic [hlscg_pkg::SEL_W-1:0] hue_sector(int r, int g, int b);
         int mx;
         int mn;
         mx = r;
         if (g > mx) mx = g;
         if (b > mx) mx = b;
         mn = r;
         if (g < mn) mn = g;
         if (b < mn) mn = b;
         if (mx == mn) return hlscg_pkg::SEL_HUE_RED;
         if (mx == r) return (g == r) ? hlscg_pkg::SEL_HUE_YELLOW : hlscg_pkg::SEL_HUE_RED;
         if (mx == g) begin
            if (b < r) return hlscg_pkg::SEL_HUE_YELLOW;
            if (b < g) return hlscg_pkg::SEL_HUE_GREEN;
            return hlscg_pkg::SEL_HUE_CYAN;
         end
         return (r < g) ? hlscg_pkg::SEL_HUE_CYAN : hlscg_pkg::SEL_HUE_BLUE;
      endfunction

      function bit in_class(hlscg_pkg::pixel_type p);
         int luma;
         luma = int'(hlscg_pkg::LUMA_KR) * int'(p.red)
              + int'(hlscg_pkg::LUMA_KG) * int'(p.green)
              + int'(hlscg_pkg::LUMA_KB) * int'(p.blue);
         case (class_sel)
            hlscg_pkg::SEL_ALL: return 1'b1;
            hlscg_pkg::SEL_HUE_RED, hlscg_pkg::SEL_HUE_YELLOW, hlscg_pkg::SEL_HUE_GREEN,
            hlscg_pkg::SEL_HUE_CYAN, hlscg_pkg::SEL_HUE_BLUE:
               return hue_sector(int'(p.red), int'(p.green), int'(p.blue)) == class_sel;
            hlscg_pkg::SEL_LUMA_BRIGHT: return luma > int'(hlscg_pkg::LUMA_BRIGHT);
            hlscg_pkg::SEL_LUMA_MID:
               return luma > int'(hlscg_pkg::LUMA_DARK) &&
                      luma <= int'(hlscg_pkg::LUMA_BRIGHT);
            hlscg_pkg::SEL_LUMA_DARK: return luma <= int'(hlscg_pkg::LUMA_DARK);
            default: return 1'b0;
         endcase
      endfunction

      // Round half up: floor((N * 2^F + 10^6) / (2 * 10^6)); non-positive N gives 0.
      function longint channel_gain(longint f1, longint f2, longint fk);
         longint n;
         n = f1 * f2 * fk;
         if (n <= 0) return '0;
         return ((n << hlscg_pkg::GAIN_FRAC_BITS) + 1000000) / 2000000;
      endfunction

      function logic [hlscg_pkg::PIX_W-1:0] scaled(logic [hlscg_pkg::PIX_W-1:0] x,
                                                   longint gain);
         longint v;
         v = (longint'(x) * gain) >>> hlscg_pkg::GAIN_FRAC_BITS;
         return (v > longint'(PIX_MAX)) ? PIX_MAX : v[hlscg_pkg::PIX_W-1:0];
      endfunction

      function void note_request(hlscg_pkg::pixel_type p);
         graded_pixel_type g;
         longint fc;
         longint fm;
         longint fy;
         longint fk;
         fc = longint'(hlscg_pkg::FAC_BASE) - longint'(cyan);
         fm = longint'(hlscg_pkg::FAC_BASE) - longint'(magenta);
         fy = longint'(hlscg_pkg::FAC_BASE) + longint'(yellow);
         fk = longint'(hlscg_pkg::FAC_BLACK_BASE) + longint'(black);
         if (in_class(p)) begin
            g.red     = scaled(p.red, channel_gain(fc, fm, fk));
            g.green   = scaled(p.green, channel_gain(fc, fy, fk));
            g.blue    = scaled(p.blue, channel_gain(fm, fy, fk));
            g.matched = 1'b1;
         end else begin
            g.red     = p.red;
            g.green   = p.green;
            g.blue    = p.blue;
            g.matched = 1'b0;
         end
         graded_pixels.push_back(g);
      endfunction

      function void compare_field(string name, logic [hlscg_pkg::PIX_W-1:0] want,
                                  logic [hlscg_pkg::PIX_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(graded_pixel_type got);
         graded_pixel_type want;
         if (graded_pixels.size() == 0) begin
            $error("result with no request outstanding: %0d %0d %0d matched %0d",
                   got.red, got.green, got.blue, got.matched);
            errors++;
            return;
         end
         want = graded_pixels.pop_front();
         compare_field("red_out", want.red, got.red);
         compare_field("green_out", want.green, got.green);
         compare_field("blue_out", want.blue, got.blue);
         compare_field("matched", hlscg_pkg::PIX_W'(want.matched),
                       hlscg_pkg::PIX_W'(got.matched));
      endfunction

      function int pending();
         return graded_pixels.size();
      endfunction
   endclass

   // Drive every input to a known level from time zero.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [hlscg_pkg::PIX_W-1:0] req_red_in = '0;
   logic [hlscg_pkg::PIX_W-1:0] req_green_in = '0;
   logic [hlscg_pkg::PIX_W-1:0] req_blue_in = '0;
   logic rsp_valid;
   logic [hlscg_pkg::PIX_W-1:0] rsp_red_out;
   logic [hlscg_pkg::PIX_W-1:0] rsp_green_out;
   logic [hlscg_pkg::PIX_W-1:0] rsp_blue_out;
   logic rsp_matched;
   logic csr_write_enable = 1'b0;
   logic [hlscg_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [hlscg_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   pixel_gain_scoreboard_type sb;

   // Corner pixels: extremes, every hue tie rule, and both luma thresholds
   // hit exactly and missed by one blue step.
   hlscg_pkg::pixel_type corner_pixels [CORNER_COUNT] = '{
      '{8'd0,   8'd0,   8'd0},     // black, gray
      '{8'd255, 8'd255, 8'd255},   // white, gray
      '{8'd255, 8'd0,   8'd0},
      '{8'd0,   8'd255, 8'd0},
      '{8'd0,   8'd0,   8'd255},
      '{8'd200, 8'd200, 8'd10},    // red on top, green ties it
      '{8'd200, 8'd10,  8'd200},   // red on top, blue ties it
      '{8'd100, 8'd200, 8'd50},    // green on top, blue below red
      '{8'd80,  8'd200, 8'd80},    // green on top, blue equals red
      '{8'd10,  8'd200, 8'd200},   // green on top, blue ties it
      '{8'd10,  8'd100, 8'd200},   // blue on top, red below green
      '{8'd100, 8'd100, 8'd200},   // blue on top, red equals green
      '{8'd76,  8'd248, 8'd0},     // luma exactly on the bright bound
      '{8'd76,  8'd248, 8'd1},     // one step into bright
      '{8'd38,  8'd124, 8'd0},     // luma exactly on the dark bound
      '{8'd38,  8'd124, 8'd1},     // one step into mid
      '{8'd128, 8'd127, 8'd1},
      '{8'd1,   8'd254, 8'd128}
   };

   hue_luma_selective_color_gain_core uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .rsp_valid        (rsp_valid),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_matched      (rsp_matched),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Sample results at the edge that ends their cycle; the values read here
   // are the ones held during that cycle.
   always @(posedge clock) begin : watch_results
      graded_pixel_type seen;
      if (!reset && rsp_valid) begin
         seen.red     = rsp_red_out;
         seen.green   = rsp_green_out;
         seen.blue    = rsp_blue_out;
         seen.matched = rsp_matched;
         sb.check_result(seen);
      end
   end

   // Present one request and hold it until an edge finds busy low.
   // Leave start high on return; the caller decides whether to drop it.
   task automatic send_pixel(hlscg_pkg::pixel_type p);
      start        <= 1'b1;
      req_red_in   <= p.red;
      req_green_in <= p.green;
      req_blue_in  <= p.blue;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(p);
   endtask

   // Write one register; leave the enable high so writes can go back to back.
   task automatic write_reg(logic [hlscg_pkg::CSR_IDX_W-1:0] idx,
                            logic [hlscg_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Advance until every graded request has come back.
   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Mostly random pixels, with a share of gray, tied channels and corners
   // so the hue tie rules and luma bounds show up under every setting.
   function automatic hlscg_pkg::pixel_type random_pixel();
      hlscg_pkg::pixel_type p;
      p.red   = hlscg_pkg::PIX_W'($urandom_range(255));
      p.green = hlscg_pkg::PIX_W'($urandom_range(255));
      p.blue  = hlscg_pkg::PIX_W'($urandom_range(255));
      case ($urandom_range(5))
         0: begin
            p.green = p.red;
            p.blue  = p.red;
         end
         1: p = corner_pixels[$urandom_range(CORNER_COUNT - 1)];
         2: begin
            case ($urandom_range(2))
               0: p.green = p.red;
               1: p.blue  = p.red;
               default: p.blue = p.green;
            endcase
         end
         default: ;
      endcase
      return p;
   endfunction

   // Early phases walk every select code, 9..15 included; the closing phases
   // select everything and pin all adjusts at one extreme each.
   task automatic configure(int phase);
      logic [hlscg_pkg::CSR_DATA_W-1:0] adj [4];
      logic [hlscg_pkg::CSR_DATA_W-1:0] sel_word;
      sel_word = hlscg_pkg::CSR_DATA_W'($urandom_range(255));
      sel_word[hlscg_pkg::SEL_W-1:0] = (phase < SEL_SPAN) ? hlscg_pkg::SEL_W'(phase)
                                                          : hlscg_pkg::SEL_ALL;
      for (int i = 0; i < 4; i++) begin
         if (phase >= SEL_SPAN) begin
            case (phase - SEL_SPAN)
               0: adj[i] = hlscg_pkg::CSR_DATA_W'(100);
               1: adj[i] = hlscg_pkg::CSR_DATA_W'(-100);
               2: adj[i] = hlscg_pkg::CSR_DATA_W'(-128);
               default: adj[i] = hlscg_pkg::CSR_DATA_W'(127);
            endcase
         end else begin
            case ($urandom_range(4))
               0: adj[i] = hlscg_pkg::CSR_DATA_W'($urandom_range(255));
               1: adj[i] = '0;
               2: adj[i] = $urandom_range(1) ? hlscg_pkg::CSR_DATA_W'(100)
                                             : hlscg_pkg::CSR_DATA_W'(-100);
               default: adj[i] = hlscg_pkg::CSR_DATA_W'($urandom_range(200) - 100);
            endcase
         end
      end
      write_reg(hlscg_pkg::CSR_COLOR_SELECT, sel_word);
      write_reg(hlscg_pkg::CSR_CYAN_ADJUST, adj[0]);
      write_reg(hlscg_pkg::CSR_MAGENTA_ADJUST, adj[1]);
      write_reg(hlscg_pkg::CSR_YELLOW_ADJUST, adj[2]);
      write_reg(hlscg_pkg::CSR_BLACK_ADJUST, adj[3]);
      // Unused indexes must leave every register alone.
      if (phase == 0) begin
         for (int idx = int'(hlscg_pkg::CSR_BLACK_ADJUST) + 1;
              idx < (1 << hlscg_pkg::CSR_IDX_W); idx++)
            write_reg(hlscg_pkg::CSR_IDX_W'(idx),
                      hlscg_pkg::CSR_DATA_W'($urandom_range(255)));
      end
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int gap_odds;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Run the corner pixels at reset settings: unity gain, all selected.
      foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
      start <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         // Reprogram only with the pipeline empty.
         drain();
         configure(phase);
         if (phase >= PHASES - QUIET_PHASES || phase % 4 == 3)
            gap_odds = 0;
         else
            gap_odds = $urandom_range(40, 10);
         repeat (ITEMS_PER_PHASE) begin
            send_pixel(random_pixel());
            if (gap_odds > 0 && $urandom_range(99) < gap_odds) begin
               start <= 1'b0;
               repeat ($urandom_range(MAX_BURST, 1)) @(posedge clock);
            end
         end
         start <= 1'b0;
      end

      // Wait for the tail, then watch a little longer for strays.
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("tb_hue_luma_selective_color_gain_core: done, clean");
      else
         $display("tb_hue_luma_selective_color_gain_core: done, errors");
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("tb_hue_luma_selective_color_gain_core: done, errors");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/hlscg_pkg.sv
rtl/hlscg_gain.sv
rtl/hue_luma_selective_color_gain_core.sv
bench/tb_hue_luma_selective_color_gain_core.sv
